/* src/lowrank_matvec_accumulate_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the low-rank matrix-vector accumulate block
// Shared concurrent assertion templates, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef LOWRANK_MATVEC_ACCUMULATE_ASSERT_SVH
`define LOWRANK_MATVEC_ACCUMULATE_ASSERT_SVH

// same-cycle implication
`define LMA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lma assertion failed");

// next-cycle implication
`define LMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lma assertion failed");

`endif

/* src/lma_pkg.sv */
// ---------------------------------------------------------------------------
// lma_pkg
// Types, codes and constants shared by the low-rank matvec accumulate block.
// ---------------------------------------------------------------------------
package lma_pkg;

	localparam int MAX_IN_DEF   = 256;
	localparam int MAX_OUT_DEF  = 64;
	localparam int MAX_RANK_DEF = 16;

	// widest index fields carried in the command word
	localparam int CMD_IDX_W  = 12;
	localparam int CMD_RANK_W = 6;
	localparam int CMD_OUT_W  = 6;

	localparam int DRAIN_CYCLES   = 6;
	localparam int DRAIN_W        = 3;
	localparam int OUT_FIFO_DEPTH = 8;

	localparam logic [2:0] OP_LOAD_X = 3'd0;
	localparam logic [2:0] OP_LOAD_V = 3'd1;
	localparam logic [2:0] OP_LOAD_U = 3'd2;
	localparam logic [2:0] OP_LOAD_S = 3'd3;
	localparam logic [2:0] OP_LOAD_Y = 3'd4;
	localparam logic [2:0] OP_RUN    = 3'd5;

	localparam logic [1:0] REG_IN_COUNT    = 2'd0;
	localparam logic [1:0] REG_OUT_COUNT   = 2'd1;
	localparam logic [1:0] REG_RANK_IN_USE = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROJ,
		ST_DRAIN,
		ST_UPDATE,
		ST_FLUSH
	} state_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_PROJ,
		CMD_UPDATE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic                  first;
		logic                  last_term;
		logic                  last_item;
		logic [CMD_IDX_W-1:0]  idx;
		logic [CMD_RANK_W-1:0] rank;
		logic [CMD_OUT_W-1:0]  outi;
	} cmd_t;

	typedef struct packed {
		logic               en;
		logic [2:0]         op;
		logic [7:0]         row;
		logic [3:0]         col;
		logic signed [15:0] value;
	} load_t;

	typedef struct packed {
		logic out_pop;
	} dp_status_t;

endpackage

/* src/lma_if.sv */
// ---------------------------------------------------------------------------
// lma channel interfaces
// Input item, result and configuration write channels.
// ---------------------------------------------------------------------------
interface lma_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         op;
	logic [7:0]         row;
	logic [3:0]         col;
	logic signed [15:0] value;

	modport source (output valid, op, row, col, value, input ready);
	modport sink (input valid, op, row, col, value, output ready);
endinterface

interface lma_out_if;
	logic               valid;
	logic               ready;
	logic [5:0]         out_index;
	logic signed [15:0] out_value;
	logic               last;

	modport source (output valid, out_index, out_value, last, input ready);
	modport sink (input valid, out_index, out_value, last, output ready);
endinterface

interface lma_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [8:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* src/lma_ctrl.sv */
// ---------------------------------------------------------------------------
// lma_ctrl
// Run sequencer: holds the count registers and walks the two MAC loops.
// ---------------------------------------------------------------------------
module lma_ctrl #(
	parameter int MAX_IN   = lma_pkg::MAX_IN_DEF,
	parameter int MAX_OUT  = lma_pkg::MAX_OUT_DEF,
	parameter int MAX_RANK = lma_pkg::MAX_RANK_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	lma_cfg_if.sink             cfg,
	input  logic                run_start,
	output logic                idle,
	output lma_pkg::cmd_t       cmd,
	input  lma_pkg::dp_status_t status
);
	import lma_pkg::*;

	localparam int IW = $clog2(MAX_IN);
	localparam int RW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
	localparam int OW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
	localparam int CW = $clog2(OUT_FIFO_DEPTH + 1);
	localparam int IN_RST   = (MAX_IN < 256) ? MAX_IN : 256;
	localparam int OUT_RST  = (MAX_OUT < 64) ? MAX_OUT : 64;
	localparam int RANK_RST = (MAX_RANK < 16) ? MAX_RANK : 16;

	state_t          state_q, state_d;
	logic [IW-1:0]   i_q;
	logic [RW-1:0]   r_q;
	logic [OW-1:0]   o_q;
	logic [DRAIN_W-1:0] wait_q;
	logic [CW-1:0]   credit_q;
	logic [8:0]      in_cnt_q;
	logic [6:0]      out_cnt_q;
	logic [4:0]      rank_cnt_q;
	logic            i_last, r_last, o_last, can_issue, issue_b;

	assign cfg.ready = 1'b1;

	assign i_last    = (32'(i_q) + 1) == 32'(in_cnt_q);
	assign r_last    = (32'(r_q) + 1) == 32'(rank_cnt_q);
	assign o_last    = (32'(o_q) + 1) == 32'(out_cnt_q);
	assign can_issue = (r_q != '0) || (credit_q < CW'(OUT_FIFO_DEPTH));
	assign issue_b   = (state_q == ST_UPDATE) && can_issue;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (run_start) state_d = ST_PROJ;
			end
			ST_PROJ: begin
				if (i_last && r_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (wait_q == DRAIN_W'(DRAIN_CYCLES - 1)) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (can_issue && r_last && o_last) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (credit_q == '0) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd  = '0;
		idle = 1'b0;
		cmd.kind = CMD_NONE;
		case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
			end
			ST_PROJ: begin
				cmd.kind      = CMD_PROJ;
				cmd.first     = (i_q == '0);
				cmd.last_term = i_last;
				cmd.idx       = CMD_IDX_W'(i_q);
				cmd.rank      = CMD_RANK_W'(r_q);
			end
			ST_UPDATE: begin
				if (can_issue) begin
					cmd.kind      = CMD_UPDATE;
					cmd.first     = (r_q == '0);
					cmd.last_term = r_last;
					cmd.last_item = o_last;
					cmd.rank      = CMD_RANK_W'(r_q);
					cmd.outi      = CMD_OUT_W'(o_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			i_q        <= '0;
			r_q        <= '0;
			o_q        <= '0;
			wait_q     <= '0;
			credit_q   <= '0;
			in_cnt_q   <= 9'(IN_RST);
			out_cnt_q  <= 7'(OUT_RST);
			rank_cnt_q <= 5'(RANK_RST);
		end else begin
			state_q <= state_d;
			credit_q <= credit_q + CW'(issue_b && r_last) - CW'(status.out_pop);
			case (state_q)
				ST_IDLE: begin
					i_q    <= '0;
					r_q    <= '0;
					o_q    <= '0;
					wait_q <= '0;
				end
				ST_PROJ: begin
					if (i_last) begin
						i_q <= '0;
						r_q <= r_last ? '0 : r_q + 1'b1;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					wait_q <= wait_q + 1'b1;
				end
				ST_UPDATE: begin
					if (issue_b) begin
						if (r_last) begin
							r_q <= '0;
							o_q <= o_q + 1'b1;
						end else begin
							r_q <= r_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
			// clamp register writes into their legal range
			if (cfg.valid) begin
				case (cfg.index)
					REG_IN_COUNT: begin
						if (cfg.data == '0) in_cnt_q <= 9'd1;
						else if (32'(cfg.data) > MAX_IN) in_cnt_q <= 9'(MAX_IN);
						else in_cnt_q <= cfg.data;
					end
					REG_OUT_COUNT: begin
						if (cfg.data[6:0] == '0) out_cnt_q <= 7'd1;
						else if (32'(cfg.data[6:0]) > MAX_OUT) out_cnt_q <= 7'(MAX_OUT);
						else out_cnt_q <= cfg.data[6:0];
					end
					REG_RANK_IN_USE: begin
						if (cfg.data[4:0] == '0) rank_cnt_q <= 5'd1;
						else if (32'(cfg.data[4:0]) > MAX_RANK) rank_cnt_q <= 5'(MAX_RANK);
						else rank_cnt_q <= cfg.data[4:0];
					end
					default: ;
				endcase
			end
		end
	end

endmodule

/* src/lma_datapath.sv */
// ---------------------------------------------------------------------------
// lma_datapath
// Vector and matrix stores, shared MAC pipeline, rounding and result queue.
// ---------------------------------------------------------------------------
module lma_datapath #(
	parameter int MAX_IN   = lma_pkg::MAX_IN_DEF,
	parameter int MAX_OUT  = lma_pkg::MAX_OUT_DEF,
	parameter int MAX_RANK = lma_pkg::MAX_RANK_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lma_pkg::load_t       ld,
	input  lma_pkg::cmd_t        cmd,
	output lma_pkg::dp_status_t  status,
	lma_out_if.source            out_ch
);
	import lma_pkg::*;

	localparam int IW = $clog2(MAX_IN);
	localparam int RW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
	localparam int OW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
	localparam int LW = (IW > RW) ? IW : RW;
	localparam int AW = 34 + LW;
	localparam int PW = AW + 16;
	localparam int FW = $clog2(OUT_FIFO_DEPTH);

	typedef struct packed {
		logic [5:0]         idx;
		logic signed [15:0] val;
		logic               last;
	} res_t;

	logic signed [15:0] x_mem [MAX_IN];
	logic signed [15:0] v_mem [1 << (IW + RW)];
	logic signed [15:0] u_mem [1 << (OW + RW)];
	logic signed [15:0] s_mem [MAX_RANK];
	logic signed [15:0] t_mem [MAX_RANK];
	logic signed [15:0] y_mem [MAX_OUT];

	logic signed [15:0] x_rd_s1, v_rd_s1, u_rd_s1, t_rd_s1, s_rd_s1, y_rd_s1;
	cmd_kind_t          kind_s1, kind_s2, kind_s3, kind_s4;
	logic               first_s1, first_s2, lt_s1, lt_s2;
	logic               li_s1, li_s2, li_s3, li_s4;
	logic [RW-1:0]      r_s1, r_s2, r_s3, r_s4;
	logic [OW-1:0]      o_s1, o_s2, o_s3, o_s4;
	logic signed [31:0] prod_s2;
	logic signed [15:0] side_s2, side_s3;
	logic signed [AW-1:0] acc_q, acc_base, acc_nxt, sum_s3;
	logic signed [PW-1:0] val_s4;
	logic               vld_s3, vld_s4;
	logic signed [PW:0] rnd_a, rnd_b, sh_a, sh_b, sh_sel;
	logic signed [15:0] res_val;

	logic ok_x, ok_v, ok_u, ok_s, ok_y;

	res_t          fifo_q [OUT_FIFO_DEPTH];
	logic [FW-1:0] head_q, tail_q;
	logic [FW:0]   level_q;
	logic          push, pop;

	assign ok_x = (32'(ld.row) < MAX_IN);
	assign ok_v = ok_x && (32'(ld.col) < MAX_RANK);
	assign ok_y = (32'(ld.row) < MAX_OUT);
	assign ok_u = ok_y && (32'(ld.col) < MAX_RANK);
	assign ok_s = (32'(ld.row) < MAX_RANK);

	// stores: one write from loads or results, one registered read
	always_ff @(posedge clk) begin
		if (ld.en && ld.op == OP_LOAD_X && ok_x) x_mem[IW'(ld.row)] <= ld.value;
		x_rd_s1 <= x_mem[IW'(cmd.idx)];
	end

	always_ff @(posedge clk) begin
		if (ld.en && ld.op == OP_LOAD_V && ok_v) v_mem[{IW'(ld.row), RW'(ld.col)}] <= ld.value;
		v_rd_s1 <= v_mem[{IW'(cmd.idx), RW'(cmd.rank)}];
	end

	always_ff @(posedge clk) begin
		if (ld.en && ld.op == OP_LOAD_U && ok_u) u_mem[{OW'(ld.row), RW'(ld.col)}] <= ld.value;
		u_rd_s1 <= u_mem[{OW'(cmd.outi), RW'(cmd.rank)}];
	end

	always_ff @(posedge clk) begin
		if (ld.en && ld.op == OP_LOAD_S && ok_s) s_mem[RW'(ld.row)] <= ld.value;
		s_rd_s1 <= s_mem[RW'(cmd.rank)];
	end

	always_ff @(posedge clk) begin
		if (vld_s4 && kind_s4 == CMD_PROJ) t_mem[r_s4] <= res_val;
		t_rd_s1 <= t_mem[RW'(cmd.rank)];
	end

	always_ff @(posedge clk) begin
		if (ld.en && ld.op == OP_LOAD_Y && ok_y) y_mem[OW'(ld.row)] <= ld.value;
		else if (vld_s4 && kind_s4 == CMD_UPDATE) y_mem[o_s4] <= res_val;
		y_rd_s1 <= y_mem[OW'(cmd.outi)];
	end

	// accumulate: start from zero (projection) or y in Q.24 (update)
	always_comb begin
		if (!first_s2) acc_base = acc_q;
		else if (kind_s2 == CMD_UPDATE) acc_base = AW'(side_s2) <<< 12;
		else acc_base = '0;
		acc_nxt = acc_base + AW'(prod_s2);
	end

	// round to nearest, ties up, then saturate
	always_comb begin
		rnd_a = $signed({val_s4[PW-1], val_s4}) + $signed((PW+1)'(1 << 23));
		rnd_b = $signed({val_s4[PW-1], val_s4}) + $signed((PW+1)'(1 << 11));
		sh_a  = rnd_a >>> 24;
		sh_b  = rnd_b >>> 12;
		sh_sel = (kind_s4 == CMD_PROJ) ? sh_a : sh_b;
		if (sh_sel > $signed((PW+1)'(32767))) res_val = 16'sh7fff;
		else if (sh_sel < -$signed((PW+1)'(32768))) res_val = -16'sh8000;
		else res_val = sh_sel[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_s1 <= CMD_NONE;
			kind_s2 <= CMD_NONE;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
		end else begin
			kind_s1 <= cmd.kind;
			kind_s2 <= kind_s1;
			vld_s3  <= (kind_s2 != CMD_NONE) && lt_s2;
			vld_s4  <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		lt_s1    <= cmd.last_term;
		li_s1    <= cmd.last_item;
		r_s1     <= RW'(cmd.rank);
		o_s1     <= OW'(cmd.outi);

		first_s2 <= first_s1;
		lt_s2    <= lt_s1;
		li_s2    <= li_s1;
		r_s2     <= r_s1;
		o_s2     <= o_s1;
		prod_s2  <= (kind_s1 == CMD_PROJ) ? x_rd_s1 * v_rd_s1 : u_rd_s1 * t_rd_s1;
		side_s2  <= (kind_s1 == CMD_PROJ) ? s_rd_s1 : y_rd_s1;

		if (kind_s2 != CMD_NONE) acc_q <= acc_nxt;
		sum_s3  <= acc_nxt;
		side_s3 <= side_s2;
		kind_s3 <= kind_s2;
		li_s3   <= li_s2;
		r_s3    <= r_s2;
		o_s3    <= o_s2;

		// projection scales the dot product by S; update passes the sum
		val_s4  <= (kind_s3 == CMD_PROJ) ? PW'(sum_s3) * PW'(side_s3) : PW'(sum_s3);
		kind_s4 <= kind_s3;
		li_s4   <= li_s3;
		r_s4    <= r_s3;
		o_s4    <= o_s3;
	end

	// result queue; credits in the controller keep it from overflowing
	assign push = vld_s4 && (kind_s4 == CMD_UPDATE);
	assign pop  = out_ch.valid && out_ch.ready;

	always_ff @(posedge clk) begin
		if (push) fifo_q[tail_q] <= '{idx: 6'(o_s4), val: res_val, last: li_s4};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			level_q <= '0;
		end else begin
			if (push) tail_q <= tail_q + 1'b1;
			if (pop) head_q <= head_q + 1'b1;
			level_q <= level_q + (FW+1)'(push) - (FW+1)'(pop);
		end
	end

	assign out_ch.valid     = (level_q != '0);
	assign out_ch.out_index = fifo_q[head_q].idx;
	assign out_ch.out_value = fifo_q[head_q].val;
	assign out_ch.last      = fifo_q[head_q].last;
	assign status.out_pop   = pop;

endmodule

/* src/lowrank_matvec_accumulate.sv */
// ---------------------------------------------------------------------------
// lowrank_matvec_accumulate
// Low-rank matrix-vector accumulate, y += U * (S .* (V^T * x)), Q4.12.
// ---------------------------------------------------------------------------
// Load words (x, V, U, S, y) are taken one per cycle and written straight
// into the stores; loads with an index outside a store and the unused op codes
// are dropped. A run word blocks the input until its last result is taken.
// One shared 16x16 MAC forms the dot products and a separate multiply scales
// each projection sum by S. The projection pass walks rank_in_use * in_count
// terms and a drain state follows; the update pass then walks out_count *
// rank_in_use terms. Results leave through an 8-deep queue; when the sink
// holds off, the update pass pauses at the start of an output element. No
// store is cleared after reset: reading an entry never loaded gives an
// undefined value. Configuration may be written only while the block is
// idle; writes are clamped into 1..maximum.
`include "lowrank_matvec_accumulate_assert.svh"

module lowrank_matvec_accumulate #(
	parameter int MAX_IN   = lma_pkg::MAX_IN_DEF,
	parameter int MAX_OUT  = lma_pkg::MAX_OUT_DEF,
	parameter int MAX_RANK = lma_pkg::MAX_RANK_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lma_in_if.sink     in_ch,
	lma_out_if.source  out_ch,
	lma_cfg_if.sink    cfg
);
	import lma_pkg::*;

	load_t      ld;
	cmd_t       cmd;
	dp_status_t status;
	logic       idle;
	logic       in_take;

	// accept items only between runs
	assign in_ch.ready  = idle;
	assign in_take      = in_ch.valid && idle;

	// hand load words straight to the stores
	assign ld.en    = in_take;
	assign ld.op    = in_ch.op;
	assign ld.row   = in_ch.row;
	assign ld.col   = in_ch.col;
	assign ld.value = in_ch.value;

	lma_ctrl #(
		.MAX_IN   (MAX_IN),
		.MAX_OUT  (MAX_OUT),
		.MAX_RANK (MAX_RANK)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.run_start (in_take && (in_ch.op == OP_RUN)),
		.idle      (idle),
		.cmd       (cmd),
		.status    (status)
	);

	lma_datapath #(
		.MAX_IN   (MAX_IN),
		.MAX_OUT  (MAX_OUT),
		.MAX_RANK (MAX_RANK)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ld     (ld),
		.cmd    (cmd),
		.status (status),
		.out_ch (out_ch)
	);

	// results are pending only while a run holds the input
	`LMA_ASSERT_NOW(a_no_result_when_idle, clk, arst_n, out_ch.valid, !in_ch.ready)
	// a run word closes the input at once
	`LMA_ASSERT_NEXT(a_run_blocks, clk, arst_n, in_ch.valid && in_ch.ready && in_ch.op == OP_RUN, !in_ch.ready)
	// the final result of a run reopens the input once the credit counter and then the state register have updated
	`LMA_ASSERT_NEXT(a_last_reopens, clk, arst_n, out_ch.valid && out_ch.ready && out_ch.last, ##1 in_ch.ready)

endmodule
